/* hdl/lc3_pkg.sv */
// ----------------------------------------------------------------------------
// LC-3 core package
// Opcodes, trap vectors, command and status codes shared by the core files.
// ----------------------------------------------------------------------------
package lc3_pkg;

   localparam logic [1:0] CMD_WRITE_MEM = 2'd0;
   localparam logic [1:0] CMD_STEP      = 2'd1;
   localparam logic [1:0] CMD_READ_MEM  = 2'd2;
   localparam logic [1:0] CMD_READ_REG  = 2'd3;

   localparam logic [1:0] STATUS_EXEC    = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_ACCESS  = 2'd2;

   localparam logic [3:0] OP_BR   = 4'd0;
   localparam logic [3:0] OP_ADD  = 4'd1;
   localparam logic [3:0] OP_LD   = 4'd2;
   localparam logic [3:0] OP_ST   = 4'd3;
   localparam logic [3:0] OP_JSR  = 4'd4;
   localparam logic [3:0] OP_AND  = 4'd5;
   localparam logic [3:0] OP_LDR  = 4'd6;
   localparam logic [3:0] OP_STR  = 4'd7;
   localparam logic [3:0] OP_RTI  = 4'd8;
   localparam logic [3:0] OP_NOT  = 4'd9;
   localparam logic [3:0] OP_LDI  = 4'd10;
   localparam logic [3:0] OP_STI  = 4'd11;
   localparam logic [3:0] OP_JMP  = 4'd12;
   localparam logic [3:0] OP_RSV  = 4'd13;
   localparam logic [3:0] OP_LEA  = 4'd14;
   localparam logic [3:0] OP_TRAP = 4'd15;

   localparam logic [7:0] TRAP_GETC = 8'd32;
   localparam logic [7:0] TRAP_OUT  = 8'd33;
   localparam logic [7:0] TRAP_PUTS = 8'd34;
   localparam logic [7:0] TRAP_IN   = 8'd35;
   localparam logic [7:0] TRAP_HALT = 8'd37;

   localparam logic [2:0] CC_N = 3'd4;
   localparam logic [2:0] CC_Z = 3'd2;
   localparam logic [2:0] CC_P = 3'd1;

   function automatic logic [2:0] cc_of(input logic [15:0] v);
      if (v == 16'd0)  return CC_Z;
      else if (v[15])  return CC_N;
      else             return CC_P;
   endfunction

endpackage

/* hdl/lc3_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read a cycle; read data registered.
// ----------------------------------------------------------------------------
module lc3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

/* hdl/lc3_cpu_core.sv */
// ----------------------------------------------------------------------------
// LC-3 processor core
// Word memory, eight registers and a sequencer that runs one command a time.
// ----------------------------------------------------------------------------
// After reset the core sweeps its memory to zero, taking no transaction
// meanwhile. Every memory access passes the one RAM port with a registered
// read. A step runs a fetch (address, then read), an execute state and a
// response state; LD/LDR add a data read, ST/STR a data write, and LDI/STI
// first read the pointer before their data access. A register read or
// refused step goes straight to the response state, a memory write passes
// a write state and a memory read a read and a wait state. The result sits
// in an output register; req_stall is high while a command is in progress or
// a result is not yet taken, so the next transaction can be taken in the
// cycle after the result is taken.
module lc3_cpu_core #(
   parameter int MEM_WORDS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_start_address,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_address,
   input  logic [15:0] req_write_data,
   input  logic [2:0]  req_reg_select,
   input  logic [7:0]  req_in_char,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_pc,
   output logic [15:0] rsp_instruction,
   output logic [2:0]  rsp_cond,
   output logic        rsp_running,
   output logic [15:0] rsp_read_value,
   output logic        rsp_out_valid,
   output logic [7:0]  rsp_out_char
);

   localparam int AW = $clog2(MEM_WORDS);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_MEMRD, ST_MEMWAIT, ST_FETCH, ST_FWAIT, ST_EXEC,
      ST_IND, ST_IWAIT, ST_DATA, ST_DWAIT, ST_RESP
   } state_type;

   state_type   state_ff, state_in;
   logic [AW:0] clr_ff, clr_in;
   logic [15:0] regs_ff [8];
   logic [15:0] regs_in [8];
   logic [15:0] pc_ff, pc_in, ir_ff, ir_in, ea_ff, ea_in;
   logic [2:0]  cc_ff, cc_in;
   logic        run_ff, run_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [15:0] wd_ff, wd_in;
   logic [7:0]  ch_ff, ch_in;
   logic        rv_ff, rv_in;
   logic [1:0]  st_ff, st_in;
   logic [15:0] rd_ff, rd_in;
   logic        ov_ff, ov_in;
   logic [7:0]  oc_ff, oc_in;

   logic          ram_we;
   logic [15:0]   ram_addr;
   logic [15:0]   ram_wd, ram_q;
   logic [AW-1:0] ram_idx;

   // RAM address wraps modulo memory size
   assign ram_idx = (state_ff == ST_CLEAR) ? clr_ff[AW-1:0] : ram_addr[AW-1:0];

   lc3_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_mem (
      .clock(clock), .wr_en(ram_we), .addr(ram_idx),
      .wr_data(ram_wd), .rd_data(ram_q)
   );

   logic        accept;
   logic [3:0]  op;
   logic [2:0]  dr, sr1;
   logic [15:0] off9, off6, off11, opb, sum;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || rv_ff;
   assign csr_ready = (state_ff == ST_IDLE) && !rv_ff;

   assign op    = ir_ff[15:12];
   assign dr    = ir_ff[11:9];
   assign sr1   = ir_ff[8:6];
   assign off9  = {{7{ir_ff[8]}}, ir_ff[8:0]};
   assign off6  = {{10{ir_ff[5]}}, ir_ff[5:0]};
   assign off11 = {{5{ir_ff[10]}}, ir_ff[10:0]};
   assign opb   = ir_ff[5] ? {{11{ir_ff[4]}}, ir_ff[4:0]} : regs_ff[ir_ff[2:0]];

   // Shared adder: address generation and ADD
   always_comb begin
      case (op)
         lc3_pkg::OP_ADD:                 sum = regs_ff[sr1] + opb;
         lc3_pkg::OP_LDR, lc3_pkg::OP_STR: sum = regs_ff[sr1] + off6;
         lc3_pkg::OP_JSR:                 sum = pc_ff + off11;
         default:                         sum = pc_ff + off9;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      regs_in  = regs_ff;
      pc_in    = pc_ff;
      ir_in    = ir_ff;
      ea_in    = ea_ff;
      cc_in    = cc_ff;
      run_in   = run_ff;
      cmd_in   = cmd_ff;
      wd_in    = wd_ff;
      ch_in    = ch_ff;
      rv_in    = rv_ff;
      st_in    = st_ff;
      rd_in    = rd_ff;
      ov_in    = ov_ff;
      oc_in    = oc_ff;
      ram_we   = 1'b0;
      ram_addr = ea_ff;
      ram_wd   = 16'd0;

      if (rv_ff && !rsp_stall) rv_in = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(MEM_WORDS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (csr_valid && csr_ready) pc_in = csr_start_address;
            if (accept) begin
               cmd_in = req_command;
               ea_in  = req_address;
               wd_in  = req_write_data;
               ch_in  = req_in_char;
               ov_in  = 1'b0;
               oc_in  = 8'd0;
               rd_in  = 16'd0;
               st_in  = lc3_pkg::STATUS_ACCESS;
               case (req_command)
                  lc3_pkg::CMD_WRITE_MEM: state_in = ST_MEMRD;
                  lc3_pkg::CMD_READ_MEM:  state_in = ST_MEMRD;
                  lc3_pkg::CMD_STEP: begin
                     if (run_ff) state_in = ST_FETCH;
                     else begin
                        st_in    = lc3_pkg::STATUS_REFUSED;
                        state_in = ST_RESP;
                     end
                  end
                  default: begin
                     rd_in    = regs_ff[req_reg_select];
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_MEMRD: begin
            if (cmd_ff == lc3_pkg::CMD_WRITE_MEM) begin
               ram_we   = 1'b1;
               ram_wd   = wd_ff;
               state_in = ST_RESP;
            end else begin
               state_in = ST_MEMWAIT;
            end
         end
         ST_MEMWAIT: begin
            rd_in    = ram_q;
            state_in = ST_RESP;
         end
         ST_FETCH: begin
            ram_addr = pc_ff;
            state_in = ST_FWAIT;
         end
         ST_FWAIT: begin
            ir_in    = ram_q;
            pc_in    = pc_ff + 16'd1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            st_in    = lc3_pkg::STATUS_EXEC;
            state_in = ST_RESP;
            ea_in    = sum;
            case (op)
               lc3_pkg::OP_BR: if ((dr & cc_ff) != 3'd0) pc_in = sum;
               lc3_pkg::OP_ADD: begin
                  regs_in[dr] = sum;
                  cc_in = lc3_pkg::cc_of(sum);
               end
               lc3_pkg::OP_AND: begin
                  regs_in[dr] = regs_ff[sr1] & opb;
                  cc_in = lc3_pkg::cc_of(regs_ff[sr1] & opb);
               end
               lc3_pkg::OP_NOT: begin
                  regs_in[dr] = ~regs_ff[sr1];
                  cc_in = lc3_pkg::cc_of(~regs_ff[sr1]);
               end
               lc3_pkg::OP_LEA: begin
                  regs_in[dr] = sum;
                  cc_in = lc3_pkg::cc_of(sum);
               end
               lc3_pkg::OP_LD, lc3_pkg::OP_LDR, lc3_pkg::OP_ST,
               lc3_pkg::OP_STR: state_in = ST_DATA;
               lc3_pkg::OP_LDI, lc3_pkg::OP_STI: state_in = ST_IND;
               lc3_pkg::OP_JSR: begin
                  regs_in[7] = pc_ff;
                  pc_in = ir_ff[11] ? sum : regs_ff[sr1];
               end
               lc3_pkg::OP_JMP: pc_in = regs_ff[sr1];
               lc3_pkg::OP_RTI: begin
                  run_in = 1'b0;
                  cc_in  = lc3_pkg::CC_P;
               end
               lc3_pkg::OP_TRAP: begin
                  case (ir_ff[7:0])
                     lc3_pkg::TRAP_GETC, lc3_pkg::TRAP_IN: begin
                        regs_in[0] = {8'd0, ch_ff};
                        cc_in = lc3_pkg::cc_of({8'd0, ch_ff});
                     end
                     lc3_pkg::TRAP_OUT: begin
                        ov_in = 1'b1;
                        oc_in = regs_ff[0][7:0];
                     end
                     lc3_pkg::TRAP_HALT: begin
                        run_in = 1'b0;
                        cc_in  = lc3_pkg::CC_P;
                     end
                     default: ;
                  endcase
               end
               default: ;
            endcase
         end
         // Pointer read for LDI and STI
         ST_IND:  state_in = ST_IWAIT;
         ST_IWAIT: begin
            ea_in    = ram_q;
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (op == lc3_pkg::OP_ST || op == lc3_pkg::OP_STR || op == lc3_pkg::OP_STI) begin
               ram_we   = 1'b1;
               ram_wd   = regs_ff[dr];
               state_in = ST_RESP;
            end else begin
               state_in = ST_DWAIT;
            end
         end
         ST_DWAIT: begin
            regs_in[dr] = ram_q;
            cc_in       = lc3_pkg::cc_of(ram_q);
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            rv_in    = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         for (int i = 0; i < 8; i++) regs_ff[i] <= 16'd0;
         pc_ff    <= 16'd0;
         ir_ff    <= 16'd0;
         cc_ff    <= lc3_pkg::CC_Z;
         run_ff   <= 1'b1;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         regs_ff  <= regs_in;
         pc_ff    <= pc_in;
         ir_ff    <= ir_in;
         cc_ff    <= cc_in;
         run_ff   <= run_in;
         rv_ff    <= rv_in;
      end
      ea_ff  <= ea_in;
      cmd_ff <= cmd_in;
      wd_ff  <= wd_in;
      ch_ff  <= ch_in;
      st_ff  <= st_in;
      rd_ff  <= rd_in;
      ov_ff  <= ov_in;
      oc_ff  <= oc_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = st_ff;
   assign rsp_pc          = pc_ff;
   assign rsp_instruction = ir_ff;
   assign rsp_cond        = cc_ff;
   assign rsp_running     = run_ff;
   assign rsp_read_value  = rd_ff;
   assign rsp_out_valid   = ov_ff;
   assign rsp_out_char    = oc_ff;

endmodule

/* hdl/lc3_checker.sv */
// ----------------------------------------------------------------------------
// LC-3 core port checker
// Watches the ports of the core over time.
// ----------------------------------------------------------------------------
module lc3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [2:0]  rsp_cond,
   input logic        rsp_running,
   input logic        rsp_out_valid
);

   // a stalled result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result dropped while stalled");

   // no new transaction taken while a result waits
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken with result pending");

   // condition code one-hot whenever a result is valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot(rsp_cond))
      else $error("condition code not one-hot");

   // refused step only when halted; character only from an executed step
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lc3_pkg::STATUS_REFUSED) |-> !rsp_running && !rsp_out_valid)
      else $error("refused step while running");

endmodule

bind lc3_cpu_core lc3_checker u_lc3_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_cond(rsp_cond), .rsp_running(rsp_running), .rsp_out_valid(rsp_out_valid)
);
